/* rtl/core/snef_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snef_pkg
// Types and constants shared by the SSE / NDJSON event framer modules.
// ----------------------------------------------------------------------------
package snef_pkg;

    // Input action codes.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOS  = 1'b1;

    // Result kind codes.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Line mode codes.
    localparam logic MODE_SSE    = 1'b0;
    localparam logic MODE_NDJSON = 1'b1;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Field name "data".
    localparam logic [0:3][7:0] DATA_WORD = {8'h64, 8'h61, 8'h74, 8'h61};
    localparam logic [2:0]      DATA_LEN  = 3'd4;

    typedef enum logic [2:0] {
        PH_START,
        PH_MATCH,
        PH_SKIP,
        PH_VFIRST,
        PH_VBODY
    } phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    // Parser state carried from one request to the next.
    typedef struct packed {
        phase_t     line_phase;
        logic [2:0] match_count;
        logic       cr_pending;
        logic       have_data;
        logic       line_nonempty;
    } parse_state_t;

    // One result without its position marker.
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } result_t;

    // All results caused by one request, as queued between front and back.
    typedef struct packed {
        logic [1:0]      count;
        result_t [1:0]   res;
    } bundle_t;

    // Outcome of one content byte.
    typedef struct packed {
        parse_state_t st;
        logic         emit;
        logic [7:0]   data;
    } content_out_t;

endpackage

/* rtl/core/snef_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snef_front
// Accepts stream requests, runs the line parser and queues the results.
// ----------------------------------------------------------------------------
module snef_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  snef_pkg::in_item_t in_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               queue_full,
    output logic               push,
    output snef_pkg::bundle_t  push_data
);

    logic                   line_mode_reg;
    snef_pkg::parse_state_t state_reg;
    snef_pkg::parse_state_t state_next;
    snef_pkg::bundle_t      bundle;
    logic                   accept;

    function automatic snef_pkg::content_out_t content_f(
        input snef_pkg::parse_state_t st,
        input logic                   mode,
        input logic [7:0]             c
    );
        snef_pkg::content_out_t r;
        r.st   = st;
        r.emit = 1'b0;
        r.data = c;
        if (mode == snef_pkg::MODE_NDJSON)
        begin
            r.emit             = 1'b1;
            r.st.line_nonempty = 1'b1;
        end
        else
        begin
            unique case (st.line_phase)
                snef_pkg::PH_START:
                begin
                    if (c == snef_pkg::DATA_WORD[0])
                    begin
                        r.st.line_phase  = snef_pkg::PH_MATCH;
                        r.st.match_count = 3'd1;
                    end
                    else
                    begin
                        r.st.line_phase = snef_pkg::PH_SKIP;
                    end
                end
                snef_pkg::PH_MATCH:
                begin
                    if (st.match_count < snef_pkg::DATA_LEN &&
                        c == snef_pkg::DATA_WORD[st.match_count[1:0]])
                    begin
                        r.st.match_count = st.match_count + 3'd1;
                    end
                    else if (st.match_count == snef_pkg::DATA_LEN &&
                             c == snef_pkg::CHAR_COLON)
                    begin
                        // A second data line in one event is joined with LF.
                        r.emit          = st.have_data;
                        r.data          = snef_pkg::CHAR_LF;
                        r.st.have_data  = 1'b1;
                        r.st.line_phase = snef_pkg::PH_VFIRST;
                    end
                    else
                    begin
                        r.st.line_phase = snef_pkg::PH_SKIP;
                    end
                end
                snef_pkg::PH_VFIRST:
                begin
                    r.st.line_phase = snef_pkg::PH_VBODY;
                    r.emit          = (c != snef_pkg::CHAR_SPACE);
                end
                snef_pkg::PH_VBODY:
                begin
                    r.emit = 1'b1;
                end
                default:
                begin
                    r.st.line_phase = snef_pkg::PH_SKIP;
                end
            endcase
        end
        return r;
    endfunction

    always_comb
    begin
        snef_pkg::parse_state_t st;
        snef_pkg::content_out_t c0;
        snef_pkg::content_out_t c1;
        logic [1:0]             cnt;
        logic                   eos;

        st          = state_reg;
        cnt         = 2'd0;
        bundle.res  = '0;
        c0          = '0;
        c1          = '0;
        eos         = (in_data.action == snef_pkg::ACT_EOS);

        if (eos || in_data.in_byte == snef_pkg::CHAR_LF)
        begin
            // End of line; a held CR is dropped.
            if (line_mode_reg == snef_pkg::MODE_NDJSON)
            begin
                if (st.line_nonempty)
                begin
                    bundle.res[cnt[0]] = '{kind: snef_pkg::KIND_END, data: 8'h00};
                    cnt = cnt + 2'd1;
                end
            end
            else if (st.line_phase == snef_pkg::PH_START)
            begin
                if (st.have_data)
                begin
                    bundle.res[cnt[0]] = '{kind: snef_pkg::KIND_END, data: 8'h00};
                    cnt = cnt + 2'd1;
                    st.have_data = 1'b0;
                end
            end
            else if (st.line_phase == snef_pkg::PH_MATCH &&
                     st.match_count == snef_pkg::DATA_LEN)
            begin
                // A bare "data" line adds an empty data line.
                if (st.have_data)
                begin
                    bundle.res[cnt[0]] = '{kind: snef_pkg::KIND_BYTE,
                                           data: snef_pkg::CHAR_LF};
                    cnt = cnt + 2'd1;
                end
                st.have_data = 1'b1;
            end
            if (eos && line_mode_reg == snef_pkg::MODE_SSE && st.have_data)
            begin
                bundle.res[cnt[0]] = '{kind: snef_pkg::KIND_END, data: 8'h00};
                cnt = cnt + 2'd1;
                st.have_data = 1'b0;
            end
            st.cr_pending    = 1'b0;
            st.line_phase    = snef_pkg::PH_START;
            st.match_count   = 3'd0;
            st.line_nonempty = 1'b0;
        end
        else if (in_data.in_byte == snef_pkg::CHAR_CR)
        begin
            // A second CR makes the held one ordinary content.
            if (st.cr_pending)
            begin
                c0 = content_f(st, line_mode_reg, snef_pkg::CHAR_CR);
                st = c0.st;
                if (c0.emit)
                begin
                    bundle.res[cnt[0]] = '{kind: snef_pkg::KIND_BYTE, data: c0.data};
                    cnt = cnt + 2'd1;
                end
            end
            st.cr_pending = 1'b1;
        end
        else
        begin
            if (st.cr_pending)
            begin
                st.cr_pending = 1'b0;
                c0 = content_f(st, line_mode_reg, snef_pkg::CHAR_CR);
                st = c0.st;
                if (c0.emit)
                begin
                    bundle.res[cnt[0]] = '{kind: snef_pkg::KIND_BYTE, data: c0.data};
                    cnt = cnt + 2'd1;
                end
            end
            c1 = content_f(st, line_mode_reg, in_data.in_byte);
            st = c1.st;
            if (c1.emit)
            begin
                bundle.res[cnt[0]] = '{kind: snef_pkg::KIND_BYTE, data: c1.data};
                cnt = cnt + 2'd1;
            end
        end

        bundle.count = cnt;
        state_next   = st;
    end

    assign in_stall  = queue_full;
    assign accept    = in_valid && !queue_full;
    assign push      = accept && (bundle.count != 2'd0);
    assign push_data = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_mode_reg <= snef_pkg::MODE_SSE;
            state_reg     <= '{line_phase: snef_pkg::PH_START, default: '0};
        end
        else
        begin
            if (cfg_wr_en)
            begin
                line_mode_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

endmodule

/* rtl/core/snef_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snef_queue
// Short queue of result bundles between the parser and the output stage.
// ----------------------------------------------------------------------------
module snef_queue #(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  snef_pkg::bundle_t push_data,
    input  logic              pop,
    output snef_pkg::bundle_t head,
    output logic              empty,
    output logic              full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    snef_pkg::bundle_t slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/snef_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snef_back
// Output stage: unpacks queued bundles into one registered result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module snef_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  snef_pkg::bundle_t   head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output snef_pkg::out_item_t out_data
);

    logic                out_valid_reg;
    logic                out_valid_next;
    snef_pkg::out_item_t out_data_reg;
    snef_pkg::out_item_t out_data_next;
    logic                sub_reg;
    logic                sub_next;
    logic                load;
    logic                last;
    snef_pkg::result_t   cur;

    assign load = !out_valid_reg || !out_stall;
    assign cur  = head.res[sub_reg];
    assign last = sub_reg || (head.count == 2'd1);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        sub_next       = sub_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                out_data_next = '{result_kind: cur.kind,
                                  out_byte:    cur.data,
                                  run_last:    last};
                // The bundle leaves the queue with its last result.
                pop      = last;
                sub_next = !last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

endmodule

/* rtl/core/sse_ndjson_event_framer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_ndjson_event_framer_top
// Frames an SSE or NDJSON byte stream into streamed payload bytes and end
// markers. A request's results pass through the result queue and then the
// output register. Throughput: one request per cycle while each gives at
// most one result and the output is not stalled; a request with two results
// gives them one after the other. Reset clears the parser state, the queue
// and the output valid, and selects SSE mode.
// ----------------------------------------------------------------------------
module sse_ndjson_event_framer_top #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  snef_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output snef_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data
);

    logic              push;
    logic              pop;
    logic              empty;
    logic              full;
    snef_pkg::bundle_t push_data;
    snef_pkg::bundle_t head;

    snef_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .queue_full  (full),
        .push        (push),
        .push_data   (push_data)
    );

    snef_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    snef_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* sim/tb_sse_ndjson_event_framer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sse_ndjson_event_framer_top
// Self-checking bench for the SSE / NDJSON event framer. A queue of stream
// requests feeds a bursty driver. A local model of the framer predicts the
// payload bytes and end markers of every accepted request. A monitor with
// its own stall pattern checks each result field against the prediction.
// ----------------------------------------------------------------------------
module tb_sse_ndjson_event_framer_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 325;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    snef_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    snef_pkg::out_item_t out_data;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_wr_data = 1'b0;

    snef_pkg::in_item_t  stream_requests[$];
    snef_pkg::out_item_t framed_results[$];
    int                  fail_count = 0;
    int                  cycle_count = 0;

    // Sender burst shaping.
    int burst_left = 1;
    int gap_left = 0;

    // Receiver stall pattern.
    int stall_mode = 0;
    int stall_timer = 0;
    int stall_tick = 0;

    // Local copy of the framer state and its mode register.
    snef_pkg::phase_t    fr_phase = snef_pkg::PH_START;
    logic [2:0]          fr_match = 3'd0;
    logic                fr_cr_held = 1'b0;
    logic                fr_have_data = 1'b0;
    logic                fr_line_used = 1'b0;
    logic                fr_mode = snef_pkg::MODE_SSE;
    snef_pkg::out_item_t step_out[2];
    int                  step_n;

    sse_ndjson_event_framer_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL sse_ndjson_event_framer_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Framer model
    // ------------------------------------------------------------------
    task automatic emit_result(input logic kind, input logic [7:0] b);
        if (step_n < 2)
        begin
            step_out[step_n].result_kind = kind;
            step_out[step_n].out_byte    = (kind == snef_pkg::KIND_END) ? 8'h00 : b;
            step_out[step_n].run_last    = 1'b0;
            step_n++;
        end
    endtask

    task automatic take_line_byte(input logic [7:0] c);
        if (fr_mode == snef_pkg::MODE_NDJSON)
        begin
            emit_result(snef_pkg::KIND_BYTE, c);
            fr_line_used = 1'b1;
        end
        else
        begin
            case (fr_phase)
                snef_pkg::PH_START:
                begin
                    if (c == snef_pkg::DATA_WORD[0])
                    begin
                        fr_phase = snef_pkg::PH_MATCH;
                        fr_match = 3'd1;
                    end
                    else
                    begin
                        fr_phase = snef_pkg::PH_SKIP;
                    end
                end
                snef_pkg::PH_MATCH:
                begin
                    if (fr_match < snef_pkg::DATA_LEN &&
                        c == snef_pkg::DATA_WORD[fr_match[1:0]])
                    begin
                        fr_match = fr_match + 3'd1;
                    end
                    else if (fr_match == snef_pkg::DATA_LEN && c == snef_pkg::CHAR_COLON)
                    begin
                        if (fr_have_data)
                            emit_result(snef_pkg::KIND_BYTE, snef_pkg::CHAR_LF);
                        fr_have_data = 1'b1;
                        fr_phase = snef_pkg::PH_VFIRST;
                    end
                    else
                    begin
                        fr_phase = snef_pkg::PH_SKIP;
                    end
                end
                snef_pkg::PH_VFIRST:
                begin
                    fr_phase = snef_pkg::PH_VBODY;
                    if (c != snef_pkg::CHAR_SPACE)
                        emit_result(snef_pkg::KIND_BYTE, c);
                end
                snef_pkg::PH_VBODY:
                begin
                    emit_result(snef_pkg::KIND_BYTE, c);
                end
                default:
                begin
                    fr_phase = snef_pkg::PH_SKIP;
                end
            endcase
        end
    endtask

    task automatic close_line(input logic at_eos);
        fr_cr_held = 1'b0;
        if (fr_mode == snef_pkg::MODE_NDJSON)
        begin
            if (fr_line_used)
                emit_result(snef_pkg::KIND_END, 8'h00);
        end
        else if (fr_phase == snef_pkg::PH_START)
        begin
            if (fr_have_data)
            begin
                emit_result(snef_pkg::KIND_END, 8'h00);
                fr_have_data = 1'b0;
            end
        end
        else if (fr_phase == snef_pkg::PH_MATCH && fr_match == snef_pkg::DATA_LEN)
        begin
            // A bare "data" line still opens or extends the event.
            if (fr_have_data)
                emit_result(snef_pkg::KIND_BYTE, snef_pkg::CHAR_LF);
            fr_have_data = 1'b1;
        end
        if (at_eos && fr_mode == snef_pkg::MODE_SSE && fr_have_data)
        begin
            emit_result(snef_pkg::KIND_END, 8'h00);
            fr_have_data = 1'b0;
        end
        fr_phase = snef_pkg::PH_START;
        fr_match = 3'd0;
        fr_line_used = 1'b0;
    endtask

    task automatic frame_request(input snef_pkg::in_item_t item);
        step_n = 0;
        if (item.action == snef_pkg::ACT_EOS)
        begin
            close_line(1'b1);
        end
        else if (item.in_byte == snef_pkg::CHAR_LF)
        begin
            close_line(1'b0);
        end
        else if (item.in_byte == snef_pkg::CHAR_CR)
        begin
            // The earlier CR was not followed by LF, so it is line content.
            if (fr_cr_held)
                take_line_byte(snef_pkg::CHAR_CR);
            fr_cr_held = 1'b1;
        end
        else
        begin
            if (fr_cr_held)
            begin
                fr_cr_held = 1'b0;
                take_line_byte(snef_pkg::CHAR_CR);
            end
            take_line_byte(item.in_byte);
        end
        for (int k = 0; k < step_n; k++)
        begin
            step_out[k].run_last = (k == step_n - 1);
            framed_results = {framed_results, step_out[k]};
        end
    endtask

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic               nxt_valid;
        snef_pkg::in_item_t nxt_data;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_data  = in_data;
            if (in_valid && !in_stall)
            begin
                frame_request(in_data);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (stream_requests.size() != 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_data  = stream_requests.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
            in_valid <= nxt_valid;
            in_data  <= nxt_data;
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        snef_pkg::out_item_t want;
        logic                nxt_stall;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (framed_results.size() == 0)
                begin
                    $error("unexpected result: result_kind %0d out_byte %02h run_last %0d",
                           out_data.result_kind, out_data.out_byte, out_data.run_last);
                    fail_count++;
                end
                else
                begin
                    want = framed_results.pop_front();
                    if (out_data.result_kind !== want.result_kind)
                    begin
                        $error("result_kind: expected %0d, got %0d",
                               want.result_kind, out_data.result_kind);
                        fail_count++;
                    end
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, out_data.out_byte);
                        fail_count++;
                    end
                    if (out_data.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0d, got %0d",
                               want.run_last, out_data.run_last);
                        fail_count++;
                    end
                end
            end
            if (stall_timer == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_timer = $urandom_range(20, 200);
            end
            else
            begin
                stall_timer--;
            end
            stall_tick++;
            case (stall_mode)
                1:       nxt_stall = ($urandom_range(0, 3) == 0);
                2:       nxt_stall = ($urandom_range(0, 9) < 6);
                3:       nxt_stall = (stall_tick % 3 != 0);
                default: nxt_stall = 1'b0;
            endcase
            out_stall <= nxt_stall;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        snef_pkg::in_item_t item;
        item.action  = snef_pkg::ACT_BYTE;
        item.in_byte = b;
        stream_requests = {stream_requests, item};
    endtask

    task automatic add_eos();
        snef_pkg::in_item_t item;
        item.action  = snef_pkg::ACT_EOS;
        item.in_byte = 8'($urandom_range(0, 255));
        stream_requests = {stream_requests, item};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_text_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0:       b = snef_pkg::CHAR_CR;
            1, 2:    b = 8'($urandom_range(0, 255));
            default: b = 8'($urandom_range(32, 126));
        endcase
        if (b == snef_pkg::CHAR_LF)
            b = 8'hFF;
        return b;
    endfunction

    task automatic add_content(input int n);
        repeat (n) add_byte(pick_text_byte());
    endtask

    task automatic add_line_end();
        case ($urandom_range(0, 15))
            0:
            begin
                add_byte(snef_pkg::CHAR_CR);
                add_byte(snef_pkg::CHAR_CR);
            end
            1, 2, 3, 4, 5: add_byte(snef_pkg::CHAR_CR);
            default: ;
        endcase
        add_byte(snef_pkg::CHAR_LF);
    endtask

    task automatic add_sse_line();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6:
            begin
                add_text("data:");
                if ($urandom_range(0, 1) == 0)
                    add_byte(snef_pkg::CHAR_SPACE);
                add_content($urandom_range(0, 12));
                add_line_end();
            end
            7:
            begin
                add_text("data");
                add_line_end();
            end
            8, 9:
            begin
                add_line_end();
            end
            10:
            begin
                add_byte(snef_pkg::CHAR_COLON);
                add_content($urandom_range(0, 8));
                add_line_end();
            end
            11:
            begin
                case ($urandom_range(0, 3))
                    0:       add_text("event");
                    1:       add_text("id");
                    2:       add_text("dat");
                    default: add_text("datax");
                endcase
                add_byte(snef_pkg::CHAR_COLON);
                add_content($urandom_range(0, 8));
                add_line_end();
            end
            12:
            begin
                add_text("data");
                add_content($urandom_range(1, 6));
                add_line_end();
            end
            13:
            begin
                repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
                add_line_end();
            end
            14:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    add_text("data:");
                    add_content($urandom_range(0, 6));
                end
                add_eos();
            end
            default:
            begin
                add_text("data: ");
                add_byte(snef_pkg::CHAR_CR);
                add_content($urandom_range(0, 4));
                add_byte(snef_pkg::CHAR_CR);
                add_line_end();
            end
        endcase
    endtask

    task automatic add_ndjson_line();
        case ($urandom_range(0, 9))
            7:
            begin
                add_line_end();
            end
            8:
            begin
                add_content($urandom_range(0, 6));
                add_eos();
            end
            9:
            begin
                repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
            end
            default:
            begin
                add_byte(8'h7B);
                add_content($urandom_range(0, 14));
                add_byte(8'h7D);
                add_line_end();
            end
        endcase
    endtask

    // Fills one stretch of random stream and may leave the last line open,
    // so that the following mode change lands in the middle of a line.
    task automatic fill_random(input logic as_ndjson, input int n);
        @(negedge clk);
        while (stream_requests.size() < n)
        begin
            if (as_ndjson == snef_pkg::MODE_NDJSON)
                add_ndjson_line();
            else
                add_sse_line();
        end
        if ($urandom_range(0, 1) == 0)
        begin
            add_text("data: ");
            add_content($urandom_range(1, 4));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (stream_requests.size() != 0 || in_valid || framed_results.size() != 0);
    endtask

    task automatic write_line_mode(input logic value);
        wait_drained();
        // A request that gives no result may still be inside the block.
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        fr_mode = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed SSE: space strip with a top byte and CRLF, a bare data
        // line joined with LF, blank line, comment, and a CR held at the end
        // of the stream with the lowest byte as value.
        @(negedge clk);
        add_text("data: ");
        add_byte(8'hFF);
        add_byte(snef_pkg::CHAR_CR);
        add_byte(snef_pkg::CHAR_LF);
        add_text("data");
        add_byte(snef_pkg::CHAR_LF);
        add_byte(snef_pkg::CHAR_LF);
        add_byte(snef_pkg::CHAR_COLON);
        add_byte(snef_pkg::CHAR_CR);
        add_byte(snef_pkg::CHAR_LF);
        add_text("data:");
        add_byte(8'h00);
        add_byte(snef_pkg::CHAR_CR);
        add_eos();

        // Directed NDJSON: a CR that is not followed by LF stays in the line.
        write_line_mode(snef_pkg::MODE_NDJSON);
        @(negedge clk);
        add_byte(8'h61);
        add_byte(snef_pkg::CHAR_CR);
        add_byte(snef_pkg::CHAR_CR);
        add_byte(snef_pkg::CHAR_LF);

        write_line_mode(snef_pkg::MODE_SSE);
        fill_random(snef_pkg::MODE_SSE, PHASE_ITEMS);
        write_line_mode(snef_pkg::MODE_NDJSON);
        fill_random(snef_pkg::MODE_NDJSON, PHASE_ITEMS);
        write_line_mode(snef_pkg::MODE_NDJSON);
        fill_random(snef_pkg::MODE_NDJSON, PHASE_ITEMS);
        write_line_mode(snef_pkg::MODE_SSE);
        fill_random(snef_pkg::MODE_SSE, PHASE_ITEMS);
        write_line_mode(snef_pkg::MODE_NDJSON);
        fill_random(snef_pkg::MODE_NDJSON, PHASE_ITEMS);
        write_line_mode(snef_pkg::MODE_SSE);
        fill_random(snef_pkg::MODE_SSE, PHASE_ITEMS);

        wait_drained();
        repeat (10) @(posedge clk);
        if (framed_results.size() != 0)
        begin
            $error("%0d results never arrived", framed_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS sse_ndjson_event_framer_top");
        else
            $display("FAIL sse_ndjson_event_framer_top");
        $finish;
    end

endmodule
